### hw/rtl/rv32_pkg.sv
`timescale 1ns / 1ps
package rv32_pkg;
  localparam int MemWordsDefault = 4096;

  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG    = 7'b0110011;

  localparam logic [1:0] ST_EXEC    = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_LOADED  = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [11:0] mem_word_index;
    logic [31:0] mem_word_value;
  } result_t;

  // ALU function used by both OP and OP-IMM
  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    begin
      case (f3)
        3'd0: r = alt ? a - b : a + b;
        3'd1: r = a << b[4:0];
        3'd2: r = {31'd0, $signed(a) < $signed(b)};
        3'd3: r = {31'd0, a < b};
        3'd4: r = a ^ b;
        3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
        3'd6: r = a | b;
        default: r = a & b;
      endcase
      return r;
    end
  endfunction
endpackage

### hw/rtl/rv32_exec.sv
`timescale 1ns / 1ps
module rv32_exec (
  input  logic [31:0] pc,
  input  logic [31:0] ins,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] mw,
  output logic        ok,
  output logic        reg_wr,
  output logic [31:0] reg_val,
  output logic        mem_wr,
  output logic [31:0] mem_val,
  output logic [31:0] npc,
  output logic [31:0] addr
);
  import rv32_pkg::*;

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, up;
  logic [4:0]  lane;
  logic [31:0] sh, shh;
  logic        t, lt, ltu;

  assign op    = ins[6:0];
  assign f3    = ins[14:12];
  assign f7    = ins[31:25];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign up    = {ins[31:12], 12'd0};
  assign addr  = a + ((op == OP_STORE) ? imm_s : imm_i);
  assign lane  = {addr[1:0], 3'd0};
  assign sh    = mw >> lane;
  assign shh   = mw >> {addr[1], 4'd0};
  assign lt    = $signed(a) < $signed(b);
  assign ltu   = a < b;

  always_comb begin
    ok = 1'b1; reg_wr = 1'b0; reg_val = '0; mem_wr = 1'b0; mem_val = mw;
    npc = pc + 32'd4; t = 1'b0;
    case (op)
      OP_LUI:   begin reg_wr = 1'b1; reg_val = up; end
      OP_AUIPC: begin reg_wr = 1'b1; reg_val = pc + up; end
      OP_JAL: begin
        reg_wr = 1'b1; reg_val = pc + 32'd4; npc = pc + imm_j;
      end
      OP_JALR: begin
        if (f3 != 3'd0) ok = 1'b0;
        reg_wr = 1'b1; reg_val = pc + 32'd4;
        npc = (a + imm_i) & ~32'd1;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: t = a == b;
          3'd1: t = a != b;
          3'd4: t = lt;
          3'd5: t = !lt;
          3'd6: t = ltu;
          3'd7: t = !ltu;
          default: ok = 1'b0;
        endcase
        if (t) npc = pc + imm_b;
      end
      OP_LOAD: begin
        reg_wr = 1'b1;
        case (f3)
          3'd0: reg_val = {{24{sh[7]}}, sh[7:0]};
          3'd1: reg_val = {{16{shh[15]}}, shh[15:0]};
          3'd2: reg_val = mw;
          3'd4: reg_val = {24'd0, sh[7:0]};
          3'd5: reg_val = {16'd0, shh[15:0]};
          default: ok = 1'b0;
        endcase
      end
      OP_STORE: begin
        mem_wr = 1'b1;
        case (f3)
          3'd0: mem_val = (mw & ~(32'hff << lane)) | ({24'd0, b[7:0]} << lane);
          3'd1: mem_val = (mw & ~(32'hffff << {addr[1], 4'd0}))
                          | ({16'd0, b[15:0]} << {addr[1], 4'd0});
          3'd2: mem_val = b;
          default: ok = 1'b0;
        endcase
      end
      OP_IMM: begin
        reg_wr = 1'b1;
        if (f3 == 3'd1 && f7 != 7'd0) ok = 1'b0;
        if (f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20) ok = 1'b0;
        reg_val = alu(f3, f3 == 3'd5 && f7 == 7'h20, a, imm_i);
      end
      OP_REG: begin
        reg_wr = 1'b1;
        if (f7 != 7'd0 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) ok = 1'b0;
        reg_val = alu(f3, f7 == 7'h20, a, b);
      end
      default: ok = 1'b0;
    endcase
  end
endmodule

### hw/rtl/rv32i_instruction_step.sv
`timescale 1ns / 1ps
// channel | ports                                         | direction
// in      | in_valid in_stall in_action in_word_index in_word_data | item in
// out     | out_valid out_stall out_status ... out_mem_word_value  | result out
// cfg     | cfg_we cfg_wdata                               | boot pc write
// A load item goes: accept, then result. An instruction goes: accept,
// fetch read, register file read, data memory read, write back, then result.
// The register file and word memory are synchronous RAMs; the three reads
// come in a row, each in its own state. After reset a clearing pass zeroes
// memory and the register file, but sets x2 to MEM_WORDS*4-4; no item is
// taken meanwhile. A held result blocks the next item until it is taken.
module rv32i_instruction_step #(
  parameter int MEM_WORDS = rv32_pkg::MemWordsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [11:0] in_word_index,
  input  logic [31:0] in_word_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_next_pc,
  output logic        out_reg_written,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic        out_mem_written,
  output logic [11:0] out_mem_word_index,
  output logic [31:0] out_mem_word_value
);
  import rv32_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [31:0] SpInit = 32'(MEM_WORDS * 4 - 4);

  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_FETCH = 3'd2,
                         S_REGS = 3'd3, S_DMEM = 3'd4, S_WB = 3'd5, S_OUT = 3'd6;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rf_a [32];
  logic [31:0] rf_b [32];

  logic [2:0]    state_r, state_nxt;
  logic [AW:0]   clr_r;
  logic [31:0]   pc_r;
  logic [31:0]   ins_r, a_r, b_r, mrd_r;
  result_t       res_r, res_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;
  logic          rf_we;
  logic [4:0]    rf_wa;
  logic [31:0]   rf_wd;

  logic          ok, x_rwr, x_mwr;
  logic [31:0]   x_rval, x_mval, x_npc, x_addr;

  rv32_exec u_exec (
    .pc(pc_r), .ins(ins_r), .a(a_r), .b(b_r), .mw(mrd_r),
    .ok(ok), .reg_wr(x_rwr), .reg_val(x_rval), .mem_wr(x_mwr),
    .mem_val(x_mval), .npc(x_npc), .addr(x_addr)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = res_r.status;
  assign out_next_pc = res_r.next_pc;
  assign out_reg_written = res_r.reg_written;
  assign out_reg_index = res_r.reg_index;
  assign out_reg_value = res_r.reg_value;
  assign out_mem_written = res_r.mem_written;
  assign out_mem_word_index = res_r.mem_word_index;
  assign out_mem_word_value = res_r.mem_word_value;

  always_comb begin
    mem_we = 1'b0; mem_wa = AW'(in_word_index); mem_wd = in_word_data;
    rf_we = 1'b0; rf_wa = ins_r[11:7]; rf_wd = x_rval;
    mem_ra = pc_r[AW+1:2];
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1; mem_wa = clr_r[AW-1:0]; mem_wd = '0;
        rf_we = (clr_r < (AW+1)'(32)); rf_wa = clr_r[4:0];
        rf_wd = (clr_r[4:0] == 5'd2) ? SpInit : '0;
        if (clr_r == (AW+1)'(MEM_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        if (in_action) begin
          mem_we = 1'b1; state_nxt = S_OUT;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_REGS;
      S_REGS:  state_nxt = S_DMEM;
      S_DMEM: begin
        mem_ra = x_addr[AW+1:2];
        state_nxt = S_WB;
      end
      S_WB: begin
        if (ins_r != 32'd0 && ok) begin
          rf_we = x_rwr && (ins_r[11:7] != 5'd0);
          mem_we = x_mwr; mem_wa = x_addr[AW+1:2]; mem_wd = x_mval;
        end
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (state_r == S_FETCH) ins_r <= mem[mem_ra];
    if (state_r == S_DMEM) mrd_r <= mem[mem_ra];
    if (rf_we) begin
      rf_a[rf_wa] <= rf_wd;
      rf_b[rf_wa] <= rf_wd;
    end
    if (state_r == S_REGS) begin
      a_r <= rf_a[ins_r[19:15]];
      b_r <= rf_b[ins_r[24:20]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (cfg_we) pc_r <= cfg_wdata;
      else if (state_r == S_WB && ins_r != 32'd0 && ok) pc_r <= x_npc;
    end
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.next_pc = pc_r;
    if (state_r == S_IDLE) begin
      res_nxt.status = ST_LOADED;
    end else if (ins_r == 32'd0) begin
      res_nxt.status = ST_HALT;
    end else if (!ok) begin
      res_nxt.status = ST_ILLEGAL;
    end else begin
      res_nxt.status = ST_EXEC;
      res_nxt.next_pc = x_npc;
      if (x_rwr && ins_r[11:7] != 5'd0) begin
        res_nxt.reg_written = 1'b1;
        res_nxt.reg_index = ins_r[11:7];
        res_nxt.reg_value = x_rval;
      end
      if (x_mwr) begin
        res_nxt.mem_written = 1'b1;
        res_nxt.mem_word_index = 12'(x_addr[AW+1:2]);
        res_nxt.mem_word_value = x_mval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE && in_valid && in_action) || state_r == S_WB) res_r <= res_nxt;
  end
endmodule
